// ===== src/mmfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmfq_pkg
// Shared types, constants and helpers of the min/max FIFO queue.
// ----------------------------------------------------------------------------
package mmfq_pkg;

  localparam int DEPTH  = 16;
  localparam int WIDTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [WIDTH-1:0] val_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [1:0]              cmd_t;

  localparam cmd_t CMD_PUSH  = 2'd0;
  localparam cmd_t CMD_POP   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam val_t VAL_MOST_NEG = {1'b1, {(WIDTH - 1){1'b0}}};
  localparam val_t VAL_MOST_POS = {1'b0, {(WIDTH - 1){1'b1}}};
  localparam cnt_t CNT_DEPTH    = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TRIM_RD,
    S_TRIM_CMP,
    S_APPEND,
    S_POP_UPD,
    S_FIN_RD,
    S_FIN_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cmd_load;
    logic push_fifo;
    logic set_ovf;
    logic set_unf;
    logic clear;
    logic trim_step;
    logic append;
    logic pop_upd;
    logic rd_tail;
    logic out_load;
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic trim_busy;
    logic out_free;
  } dp_stat_t;

  // circular index: (head + off) mod DEPTH, off kept below 2*DEPTH - head
  function automatic addr_t slot(addr_t head, cnt_t off);
    logic [CNT_W:0] s;
    s = {1'b0, CNT_W'(head)} + {1'b0, off};
    if (s >= (CNT_W + 1)'(DEPTH)) s = s - (CNT_W + 1)'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/mmfq_ram.sv =====
// ----------------------------------------------------------------------------
// mmfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmfq_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(NUM_WORDS)-1:0] waddr,
  input  logic [DATA_W-1:0]            wdata,
  input  logic [$clog2(NUM_WORDS)-1:0] raddr,
  output logic [DATA_W-1:0]            rdata
);

  logic [DATA_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mmfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmfq_ctrl
// Sequencer: decodes a request and steps the datapath through push trimming,
// pop matching and the final head read.
// ----------------------------------------------------------------------------
module mmfq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmfq_pkg::dp_stat_t stat,
  output mmfq_pkg::dp_ctrl_t ctrl
);
  import mmfq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.cmd_load = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        // head addresses are read here for the pop compare
        case (stat.cmd)
          CMD_PUSH: begin
            if (stat.full) begin
              ctrl.set_ovf = 1'b1;
              state_nxt    = S_FIN_RD;
            end else begin
              ctrl.push_fifo = 1'b1;
              state_nxt      = S_TRIM_RD;
            end
          end
          CMD_POP: begin
            if (stat.empty) begin
              ctrl.set_unf = 1'b1;
              state_nxt    = S_FIN_RD;
            end else begin
              state_nxt = S_POP_UPD;
            end
          end
          CMD_CLEAR: begin
            ctrl.clear = 1'b1;
            state_nxt  = S_FIN_RD;
          end
          default: state_nxt = S_FIN_RD;
        endcase
      end
      S_TRIM_RD: begin
        ctrl.rd_tail = 1'b1;
        state_nxt    = stat.trim_busy ? S_TRIM_CMP : S_APPEND;
      end
      S_TRIM_CMP: begin
        ctrl.trim_step = 1'b1;
        state_nxt      = S_TRIM_RD;
      end
      S_APPEND: begin
        ctrl.append = 1'b1;
        state_nxt   = S_FIN_RD;
      end
      S_POP_UPD: begin
        ctrl.pop_upd = 1'b1;
        state_nxt    = S_FIN_RD;
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== src/mmfq_dp.sv =====
// ----------------------------------------------------------------------------
// mmfq_dp
// Datapath: value FIFO, max and min monotonic stores, their pointers and
// the output register.
// ----------------------------------------------------------------------------
module mmfq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  mmfq_pkg::cmd_t     in_command,
  input  mmfq_pkg::val_t     in_value,
  input  mmfq_pkg::dp_ctrl_t ctrl,
  output mmfq_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output mmfq_pkg::val_t     out_front_value,
  output mmfq_pkg::val_t     out_max_value,
  output mmfq_pkg::val_t     out_min_value,
  output mmfq_pkg::cnt_t     out_entry_count,
  output logic               out_is_empty,
  output logic               out_overflow,
  output logic               out_underflow
);
  import mmfq_pkg::*;

  cmd_t  cmd_r;
  val_t  val_r;
  logic  ovf_r, unf_r;
  logic  max_act_r, min_act_r;

  addr_t fifo_head_r, max_head_r, min_head_r;
  cnt_t  fifo_cnt_r, max_cnt_r, min_cnt_r;

  logic  out_valid_r;
  val_t  front_r, max_r, min_r;
  cnt_t  count_r;
  logic  empty_r, oflag_r, uflag_r;

  val_t  fifo_rd, max_rd, min_rd;
  addr_t max_raddr, min_raddr;
  logic  max_we, min_we;
  logic  max_drop, min_drop;

  assign max_raddr = ctrl.rd_tail ? slot(max_head_r, max_cnt_r - CNT_W'(1)) : max_head_r;
  assign min_raddr = ctrl.rd_tail ? slot(min_head_r, min_cnt_r - CNT_W'(1)) : min_head_r;
  assign max_we    = ctrl.append && (max_cnt_r < CNT_DEPTH);
  assign min_we    = ctrl.append && (min_cnt_r < CNT_DEPTH);

  mmfq_ram #(.DATA_W(WIDTH), .NUM_WORDS(DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (ctrl.push_fifo),
    .waddr (slot(fifo_head_r, fifo_cnt_r)),
    .wdata (val_r),
    .raddr (fifo_head_r),
    .rdata (fifo_rd)
  );

  mmfq_ram #(.DATA_W(WIDTH), .NUM_WORDS(DEPTH)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (slot(max_head_r, max_cnt_r)),
    .wdata (val_r),
    .raddr (max_raddr),
    .rdata (max_rd)
  );

  mmfq_ram #(.DATA_W(WIDTH), .NUM_WORDS(DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (slot(min_head_r, min_cnt_r)),
    .wdata (val_r),
    .raddr (min_raddr),
    .rdata (min_rd)
  );

  // tail entry strictly beaten by the new value leaves its store
  assign max_drop = max_act_r && (max_cnt_r != '0) && (max_rd < val_r);
  assign min_drop = min_act_r && (min_cnt_r != '0) && (min_rd > val_r);

  always_ff @(posedge clk) begin
    if (ctrl.cmd_load) begin
      cmd_r <= in_command;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_head_r <= '0;
      fifo_cnt_r  <= '0;
      max_head_r  <= '0;
      max_cnt_r   <= '0;
      min_head_r  <= '0;
      min_cnt_r   <= '0;
      max_act_r   <= 1'b0;
      min_act_r   <= 1'b0;
      ovf_r       <= 1'b0;
      unf_r       <= 1'b0;
    end else begin
      if (ctrl.cmd_load) begin
        ovf_r <= 1'b0;
        unf_r <= 1'b0;
      end
      if (ctrl.set_ovf) ovf_r <= 1'b1;
      if (ctrl.set_unf) unf_r <= 1'b1;
      if (ctrl.clear) begin
        fifo_head_r <= '0;
        fifo_cnt_r  <= '0;
        max_head_r  <= '0;
        max_cnt_r   <= '0;
        min_head_r  <= '0;
        min_cnt_r   <= '0;
      end
      if (ctrl.push_fifo) begin
        fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
        max_act_r  <= 1'b1;
        min_act_r  <= 1'b1;
      end
      if (ctrl.trim_step) begin
        if (max_drop) max_cnt_r <= max_cnt_r - CNT_W'(1);
        else          max_act_r <= 1'b0;
        if (min_drop) min_cnt_r <= min_cnt_r - CNT_W'(1);
        else          min_act_r <= 1'b0;
      end
      if (max_we) max_cnt_r <= max_cnt_r + CNT_W'(1);
      if (min_we) min_cnt_r <= min_cnt_r + CNT_W'(1);
      if (ctrl.pop_upd) begin
        fifo_head_r <= slot(fifo_head_r, CNT_W'(1));
        fifo_cnt_r  <= fifo_cnt_r - CNT_W'(1);
        if ((max_cnt_r != '0) && (max_rd == fifo_rd)) begin
          max_head_r <= slot(max_head_r, CNT_W'(1));
          max_cnt_r  <= max_cnt_r - CNT_W'(1);
        end
        if ((min_cnt_r != '0) && (min_rd == fifo_rd)) begin
          min_head_r <= slot(min_head_r, CNT_W'(1));
          min_cnt_r  <= min_cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      front_r <= (fifo_cnt_r != '0) ? fifo_rd : '0;
      max_r   <= (max_cnt_r != '0) ? max_rd : VAL_MOST_NEG;
      min_r   <= (min_cnt_r != '0) ? min_rd : VAL_MOST_POS;
      count_r <= fifo_cnt_r;
      empty_r <= (fifo_cnt_r == '0);
      oflag_r <= ovf_r;
      uflag_r <= unf_r;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.full      = (fifo_cnt_r == CNT_DEPTH);
  assign stat.empty     = (fifo_cnt_r == '0);
  assign stat.trim_busy = max_act_r || min_act_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_front_value = front_r;
  assign out_max_value   = max_r;
  assign out_min_value   = min_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = empty_r;
  assign out_overflow    = oflag_r;
  assign out_underflow   = uflag_r;

endmodule

// ===== src/min_max_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// min_max_fifo_queue
// Bounded FIFO of signed values that reports front, running max and min.
// ----------------------------------------------------------------------------
// Each request pushes a value, pops the oldest one or clears the queue, and
// returns one result: front, max, min, count, empty and the overflow and
// underflow flags. Requests are handled one at a time. Clear, refused push,
// ignored pop and unused codes go straight to the final head read; a pop
// first updates the heads, and a push first drops entries from the tail of
// the max or min store: each store sits in a RAM with one registered read
// port, so one tail entry per store is read in S_TRIM_RD and compared in
// S_TRIM_CMP. A new request is accepted while the last result still waits
// in the output register.
module min_max_fifo_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mmfq_pkg::cmd_t in_command,
  input  mmfq_pkg::val_t in_value,
  output logic           out_valid,
  input  logic           out_stall,
  output mmfq_pkg::val_t out_front_value,
  output mmfq_pkg::val_t out_max_value,
  output mmfq_pkg::val_t out_min_value,
  output mmfq_pkg::cnt_t out_entry_count,
  output logic           out_is_empty,
  output logic           out_overflow,
  output logic           out_underflow
);
  import mmfq_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  mmfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mmfq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_value        (in_value),
    .ctrl            (ctrl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_max_value   (out_max_value),
    .out_min_value   (out_min_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_overflow    (out_overflow),
    .out_underflow   (out_underflow)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min/max FIFO queue.
// ----------------------------------------------------------------------------
// Requests are pushed through the input channel while a behavioral copy of
// the queue and its two monotonic candidate lists works out the result of
// each one. Results are checked in order. Both channels idle at random, the
// receiver holds off long enough to fill the block, and the last part runs
// with no idling at all.
module tb_top;
  import mmfq_pkg::*;

  localparam cmd_t CMD_NOP        = 2'd3;    // unused command code
  localparam int   RX_HOLD_CYCLES = 300;
  localparam int   TAIL_CYCLES    = 60;
  localparam int   CYCLE_LIMIT    = 400000;
  localparam int   MAX_REPORTS    = 10;

  typedef struct packed {
    val_t front_value;
    val_t max_value;
    val_t min_value;
    cnt_t entry_count;
    logic is_empty;
    logic overflow;
    logic underflow;
  } queue_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cmd_t in_command;
  val_t in_value;
  logic out_valid;
  logic out_stall;
  val_t out_front_value;
  val_t out_max_value;
  val_t out_min_value;
  cnt_t out_entry_count;
  logic out_is_empty;
  logic out_overflow;
  logic out_underflow;

  // behavioral copy of the block
  val_t          fifo_model[$];
  val_t          max_cand[$];
  val_t          min_cand[$];
  queue_result_t expected_results[$];

  int fail_cnt      = 0;
  int cycle_cnt     = 0;
  int hold_requests = 0;
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;

  min_max_fifo_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_max_value   (out_max_value),
    .out_min_value   (out_min_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_overflow    (out_overflow),
    .out_underflow   (out_underflow)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void predict_queue(cmd_t cmd, val_t value);
    queue_result_t r;
    val_t          leaving;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        if (fifo_model.size() >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          fifo_model.insert(fifo_model.size(), value);
          while (max_cand.size() > 0 && max_cand[$] < value) begin
            max_cand.delete(max_cand.size() - 1);
          end
          max_cand.insert(max_cand.size(), value);
          while (min_cand.size() > 0 && min_cand[$] > value) begin
            min_cand.delete(min_cand.size() - 1);
          end
          min_cand.insert(min_cand.size(), value);
        end
      end
      CMD_POP: begin
        if (fifo_model.size() == 0) begin
          r.underflow = 1'b1;
        end else begin
          leaving = fifo_model[0];
          fifo_model.delete(0);
          if (max_cand.size() > 0 && max_cand[0] == leaving) max_cand.delete(0);
          if (min_cand.size() > 0 && min_cand[0] == leaving) min_cand.delete(0);
        end
      end
      CMD_CLEAR: begin
        fifo_model.delete();
        max_cand.delete();
        min_cand.delete();
      end
      default: ;
    endcase
    r.front_value = (fifo_model.size() > 0) ? fifo_model[0] : '0;
    r.max_value   = (max_cand.size() > 0) ? max_cand[0] : VAL_MOST_NEG;
    r.min_value   = (min_cand.size() > 0) ? min_cand[0] : VAL_MOST_POS;
    r.entry_count = cnt_t'(fifo_model.size());
    r.is_empty    = (fifo_model.size() == 0);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    queue_result_t got;
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_front_value, out_max_value, out_min_value, out_entry_count,
              out_is_empty, out_overflow, out_underflow};
      if (expected_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result: front=%0d max=%0d min=%0d cnt=%0d",
                   got.front_value, got.max_value, got.min_value, got.entry_count);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("mismatch: exp front=%0d max=%0d min=%0d cnt=%0d e=%b o=%b u=%b",
                     want.front_value, want.max_value, want.min_value,
                     want.entry_count, want.is_empty, want.overflow, want.underflow);
            $display("          got front=%0d max=%0d min=%0d cnt=%0d e=%b o=%b u=%b",
                     got.front_value, got.max_value, got.min_value,
                     got.entry_count, got.is_empty, got.overflow, got.underflow);
          end
        end
      end
    end
  end

  // receiver: random stall bursts, plus long hold-offs on request
  initial begin : rx_stall_gen
    int burst_left;
    int hold_left;
    int holds_done;
    burst_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (rx_idle_en && burst_left > 0) begin
        out_stall = 1'b1;
        burst_left--;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall  = 1'b1;
        burst_left = $urandom_range(0, 6);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Returns at a falling edge; valid is left high when no gap follows so
  // back-to-back requests keep it asserted.
  task automatic send_req(input cmd_t cmd, input val_t value);
    int gap;
    if (!in_valid) @(negedge clk);
    in_valid   = 1'b1;
    in_command = cmd;
    in_value   = value;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_queue(cmd, value);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic tx_quiet();
    in_valid = 1'b0;
  endtask

  task automatic wait_results_drained();
    tx_quiet();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic val_t rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MOST_NEG;
      1:       return VAL_MOST_POS;
      2, 3, 4: return val_t'($urandom_range(0, 8) - 4);
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic send_random(input int push_pct);
    int   r;
    cmd_t cmd;
    r = $urandom_range(0, 99);
    if (r < 2)                                   cmd = CMD_CLEAR;
    else if (r < 4)                              cmd = CMD_NOP;
    else if ($urandom_range(0, 99) < push_pct)  cmd = CMD_PUSH;
    else                                         cmd = CMD_POP;
    send_req(cmd, rand_value());
  endtask

  task automatic test_directed();
    send_req(CMD_POP, '0);              // underflow on empty
    send_req(CMD_NOP, VAL_MOST_POS);
    send_req(CMD_CLEAR, VAL_MOST_NEG);
    send_req(CMD_PUSH, VAL_MOST_POS);
    send_req(CMD_PUSH, VAL_MOST_NEG);
    send_req(CMD_PUSH, '0);
    send_req(CMD_PUSH, -1);
    send_req(CMD_PUSH, 1);
    send_req(CMD_PUSH, VAL_MOST_NEG);   // the duplicate stays in the min list
    send_req(CMD_PUSH, VAL_MOST_POS);
    send_req(CMD_NOP, '1);
    repeat (5) send_req(CMD_POP, '1);
    send_req(CMD_PUSH, 5);
    send_req(CMD_CLEAR, '0);
    send_req(CMD_POP, '0);
    send_req(CMD_PUSH, 7);
    send_req(CMD_POP, '0);
  endtask

  // start a long receiver hold-off, fill to overflow, then drain past empty
  task automatic test_backpressure();
    send_req(CMD_CLEAR, '0);
    hold_requests++;
    repeat (DEPTH + 2) send_req(CMD_PUSH, rand_value());
    repeat (DEPTH + 1) send_req(CMD_POP, rand_value());
  endtask

  // sorted runs build a long candidate list, then one value trims it
  task automatic test_trim_runs(input int runs);
    val_t base;
    int   step;
    int   n;
    for (int run = 0; run < runs; run++) begin
      send_req(CMD_CLEAR, rand_value());
      n    = $urandom_range(4, DEPTH - 1);
      base = val_t'($urandom) >>> 1;
      step = $urandom_range(0, 1000);
      for (int i = 0; i < n; i++)
        send_req(CMD_PUSH, (run % 2 == 0) ? base - i * step : base + i * step);
      send_req(CMD_PUSH, (run % 2 == 0) ? VAL_MOST_POS : VAL_MOST_NEG);
      repeat ($urandom_range(0, 4)) send_req(CMD_POP, rand_value());
    end
  endtask

  // alternate fill-heavy and drain-heavy blocks
  task automatic test_random_mix(input int blocks);
    for (int b = 0; b < blocks; b++)
      repeat ($urandom_range(20, 50)) send_random((b % 2 == 0) ? 80 : 25);
  endtask

  task automatic test_pause_drain();
    repeat (20) send_random(70);
    wait_results_drained();
    repeat (20) send_random(40);
  endtask

  task automatic test_full_rate(input int items);
    tx_quiet();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int b = 0; b < items / 30; b++)
      repeat (30) send_random((b % 2 == 0) ? 75 : 30);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_PUSH;
    in_value   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_trim_runs(12);
    test_random_mix(24);
    test_pause_drain();
    test_full_rate(150);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
